FILE: hdl/alu8_pkg.sv
// package for the 8-bit alu with status flags
// holds operation codes and the input and result word types
// no dependencies
package alu8_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADC = 5'd0,
        OP_SBC = 5'd1,
        OP_AND = 5'd2,
        OP_ORA = 5'd3,
        OP_EOR = 5'd4,
        OP_BIT = 5'd5,
        OP_CMP = 5'd6,
        OP_ASL = 5'd7,
        OP_LSR = 5'd8,
        OP_ROL = 5'd9,
        OP_ROR = 5'd10,
        OP_INC = 5'd11,
        OP_DEC = 5'd12,
        OP_DCP = 5'd13,
        OP_ISC = 5'd14,
        OP_RLA = 5'd15,
        OP_RRA = 5'd16,
        OP_SLO = 5'd17,
        OP_SRE = 5'd18
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] reg_value;
        logic [DATA_W-1:0] mem_value;
        logic              carry_in;
        logic              zero_in;
        logic              overflow_in;
        logic              negative_in;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] reg_out;
        logic [DATA_W-1:0] mem_out;
        logic              carry_out;
        logic              zero_out;
        logic              overflow_out;
        logic              negative_out;
    } t_out_word;

endpackage

FILE: hdl/alu_8bit_with_status_flags.sv
// top level of the 8-bit alu with status flags, binary mode, classic 8-bit cpu operation set
// input register, combinational datapath, result register
// depends on alu8_pkg and alu8_core
//
// One word in, one word out. Each input word carries an operation code, the register
// and memory operands and the incoming C, Z, V and N flags; the result word carries the
// new register value, the new memory value and the four flags. A word held in the input
// register goes through the datapath into the result register once that one is empty or its
// result is being taken, and o_valid rises when the result register is loaded. The block
// accepts one word every cycle as long as the output side takes results; the input register
// and the result register each hold one word, so one more word is taken while a finished
// result waits, after which o_ready stays low until that result is taken (o_ready follows
// i_ready within the cycle). Undefined operation codes return both operands and all flags
// unchanged.
module alu_8bit_with_status_flags
    import alu8_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic      r_in_valid;
    logic      n_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_word r_out;
    t_out_word core_out;
    logic      out_load;
    logic      in_load;

    alu8_core u_core (
        .i_word (r_in),
        .o_word (core_out)
    );

    assign out_load = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || out_load;
    assign in_load  = i_valid && o_ready;

    assign n_in_valid  = in_load || (r_in_valid && !out_load);
    assign n_out_valid = out_load || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= i_word;
        end
        if (out_load) begin
            r_out <= core_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_in_valid)
        else $error("valid state not cleared by reset");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_load |=> r_in_valid && r_in == $past(i_word))
        else $error("accepted word not held in input register");

    a_undef_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && (r_in.op > OP_SRE) |=>
            o_word.reg_out == $past(r_in.reg_value) && o_word.mem_out == $past(r_in.mem_value)
            && o_word.carry_out == $past(r_in.carry_in))
        else $error("undefined operation changed a value");

    a_bit_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && (r_in.op == OP_BIT) |=>
            o_word.reg_out == $past(r_in.reg_value) && o_word.carry_out == $past(r_in.carry_in))
        else $error("bit changed register or carry");

endmodule

FILE: hdl/alu8_core.sv
// combinational datapath of the 8-bit alu
// one shared adder, one compare subtractor, shift and inc/dec units
// depends on alu8_pkg
module alu8_core
    import alu8_pkg::*;
(
    input  t_in_word  i_word,
    output t_out_word o_word
);

    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] m;
    logic              c;
    logic [DATA_W-1:0] m_asl;
    logic [DATA_W-1:0] m_lsr;
    logic [DATA_W-1:0] m_rol;
    logic [DATA_W-1:0] m_ror;
    logic [DATA_W-1:0] m_inc;
    logic [DATA_W-1:0] m_dec;
    logic [DATA_W-1:0] add_b;
    logic              add_cin;
    logic [DATA_W:0]   add_sum;
    logic [DATA_W-1:0] add_res;
    logic              add_v;
    logic [DATA_W-1:0] cmp_b;
    logic [DATA_W:0]   cmp_diff;
    logic [DATA_W-1:0] ra;
    logic [DATA_W-1:0] rm;
    logic              rc;
    logic              rz;
    logic              rv;
    logic              rn;
    logic              nz_reg;
    logic              nz_mem;

    assign a = i_word.reg_value;
    assign m = i_word.mem_value;
    assign c = i_word.carry_in;

    assign m_asl = {m[DATA_W-2:0], 1'b0};
    assign m_lsr = {1'b0, m[DATA_W-1:1]};
    assign m_rol = {m[DATA_W-2:0], c};
    assign m_ror = {c, m[DATA_W-1:1]};
    assign m_inc = m + DATA_W'(1);
    assign m_dec = m - DATA_W'(1);

    // adder operand select
    always_comb begin
        add_b   = m;
        add_cin = c;
        unique case (i_word.op)
            OP_SBC: begin
                add_b = ~m;
            end
            OP_ISC: begin
                add_b = ~m_inc;
            end
            OP_RRA: begin
                add_b   = m_ror;
                add_cin = m[0];
            end
            default: begin
                add_b   = m;
                add_cin = c;
            end
        endcase
    end

    assign add_sum = {1'b0, a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
    assign add_res = add_sum[DATA_W-1:0];
    assign add_v   = (a[DATA_W-1] ^ add_res[DATA_W-1]) & (add_b[DATA_W-1] ^ add_res[DATA_W-1]);

    assign cmp_b    = (i_word.op == OP_DCP) ? m_dec : m;
    assign cmp_diff = {1'b0, a} - {1'b0, cmp_b};

    always_comb begin
        ra     = a;
        rm     = m;
        rc     = c;
        rz     = i_word.zero_in;
        rv     = i_word.overflow_in;
        rn     = i_word.negative_in;
        nz_reg = 1'b0;
        nz_mem = 1'b0;
        unique case (i_word.op)
            OP_ADC, OP_SBC: begin
                ra     = add_res;
                rc     = add_sum[DATA_W];
                rv     = add_v;
                nz_reg = 1'b1;
            end
            OP_AND: begin
                ra     = a & m;
                nz_reg = 1'b1;
            end
            OP_ORA: begin
                ra     = a | m;
                nz_reg = 1'b1;
            end
            OP_EOR: begin
                ra     = a ^ m;
                nz_reg = 1'b1;
            end
            OP_BIT: begin
                rn = m[DATA_W-1];
                rv = m[DATA_W-2];
                rz = ((a & m) == '0);
            end
            OP_CMP, OP_DCP: begin
                rm = cmp_b;
                rc = ~cmp_diff[DATA_W];
                rz = (a == cmp_b);
                rn = cmp_diff[DATA_W-1];
            end
            OP_ASL: begin
                rm     = m_asl;
                rc     = m[DATA_W-1];
                nz_mem = 1'b1;
            end
            OP_LSR: begin
                rm     = m_lsr;
                rc     = m[0];
                nz_mem = 1'b1;
            end
            OP_ROL: begin
                rm     = m_rol;
                rc     = m[DATA_W-1];
                nz_mem = 1'b1;
            end
            OP_ROR: begin
                rm     = m_ror;
                rc     = m[0];
                nz_mem = 1'b1;
            end
            OP_INC: begin
                rm     = m_inc;
                nz_mem = 1'b1;
            end
            OP_DEC: begin
                rm     = m_dec;
                nz_mem = 1'b1;
            end
            OP_ISC: begin
                rm     = m_inc;
                ra     = add_res;
                rc     = add_sum[DATA_W];
                rv     = add_v;
                nz_reg = 1'b1;
            end
            OP_RLA: begin
                rm     = m_rol;
                rc     = m[DATA_W-1];
                ra     = a & m_rol;
                nz_reg = 1'b1;
            end
            OP_RRA: begin
                rm     = m_ror;
                ra     = add_res;
                rc     = add_sum[DATA_W];
                rv     = add_v;
                nz_reg = 1'b1;
            end
            OP_SLO: begin
                rm     = m_asl;
                rc     = m[DATA_W-1];
                ra     = a | m_asl;
                nz_reg = 1'b1;
            end
            OP_SRE: begin
                rm     = m_lsr;
                rc     = m[0];
                ra     = a ^ m_lsr;
                nz_reg = 1'b1;
            end
            default: begin
                // undefined codes pass everything through
                ra = a;
            end
        endcase
        if (nz_reg) begin
            rz = (ra == '0);
            rn = ra[DATA_W-1];
        end
        if (nz_mem) begin
            rz = (rm == '0);
            rn = rm[DATA_W-1];
        end
    end

    assign o_word.reg_out      = ra;
    assign o_word.mem_out      = rm;
    assign o_word.carry_out    = rc;
    assign o_word.zero_out     = rz;
    assign o_word.overflow_out = rv;
    assign o_word.negative_out = rn;

endmodule
